/* hdl/rbd_pkg.sv */
// rbd_pkg: shared types, constants and the pair-average function of the
// rgb565 box downscaler; used by the core and its port checker
// depends on nothing
package rbd_pkg;

  localparam int PIX_W = 16;
  typedef logic [PIX_W-1:0] pix_t;

  // rgb565 pair average: drop the lsb of red and green before the add
  localparam pix_t PAIR_MASK = 16'hf7df;

  // line store row: eight pair averages side by side
  localparam int LANES     = 8;
  localparam int LANE_BITS = 3;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int MODE_W     = 2;
  localparam int DIM_W      = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_HALF    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUARTER = 2'd1;

  localparam logic [MODE_W-1:0] SCALE_MODE_RST = 2'd0;
  localparam logic [DIM_W-1:0]  SRC_WIDTH_RST  = 10'd320;
  localparam logic [DIM_W-1:0]  SRC_HEIGHT_RST = 10'd240;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  function automatic pix_t pair_avg(input pix_t a, input pix_t b);
    logic [PIX_W:0] sum;
    sum = {1'b0, a & PAIR_MASK} + {1'b0, b & PAIR_MASK};
    if (a == b) begin
      return a;
    end
    return sum[PIX_W:1];
  endfunction

endpackage

/* hdl/rgb565_box_downscale_core.sv */
// rgb565_box_downscale_core: raster rgb565 box-filter downscaler by 2, 4 or 8
// depends on rbd_pkg (types, pair average) and rbd_ram (line store)
//
//  channel  | signals                          | transaction carries
//  ---------+----------------------------------+-------------------------------
//  pixel in | s_tvalid s_tready s_tdata s_tuser| source pixel, start of frame
//  pixel out| m_tvalid m_tready m_tdata m_tlast| scaled pixel, end of row,
//           | m_tuser                          | end of frame
//  config   | cfg_we cfg_index cfg_data        | register write, no read-back
//
// one source pixel per clock, sustained while the output is not blocked; a
// scaled pixel leaves after the source pixel that completes its block, through
// a three-stage fold and an output register
// the throughput is set by one read-modify-write of a 128-bit line store row
// per pixel, the row being read in the preceding cycle from the next position
// s_tready falls only while all three fold stages and the output register
// are full and m_tready is low
// synchronous reset clears counters, held pixel and pipeline and loads the
// register defaults; the line store is not cleared and needs no clearing pass
module rgb565_box_downscale_core #(
  parameter int MAX_WIDTH  = rbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rbd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
  // source pixels
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  rbd_pkg::pix_t                  s_tdata,   // [15:0] pixel
  input  logic                           s_tuser,   // [0] frame_start
  // scaled pixels
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output rbd_pkg::pix_t                  m_tdata,   // [15:0] scaled_pixel
  output logic                           m_tlast,   // line_end
  output logic                           m_tuser    // [0] frame_end
);

  import rbd_pkg::*;

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int RW        = $clog2(MAX_HEIGHT);
  localparam int DW        = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int DH        = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;
  localparam int RAM_DEPTH = (MAX_WIDTH + LANES - 1) / LANES;
  localparam int RA        = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int ROW_W     = LANES * PIX_W;

  // block size as a shift amount
  localparam logic [1:0] SH_2 = 2'd1;
  localparam logic [1:0] SH_4 = 2'd2;
  localparam logic [1:0] SH_8 = 2'd3;

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------
  function automatic logic [DW-1:0] eff_width(input logic [DIM_W-1:0] v);
    logic [DW-1:0] ve;
    ve = DW'(v);
    if (ve > DW'(MAX_WIDTH)) begin
      return DW'(MAX_WIDTH);
    end else if (v == '0) begin
      return DW'(1);
    end
    return ve;
  endfunction

  function automatic logic [DH-1:0] eff_height(input logic [DIM_W-1:0] v);
    logic [DH-1:0] ve;
    ve = DH'(v);
    if (ve > DH'(MAX_HEIGHT)) begin
      return DH'(MAX_HEIGHT);
    end else if (v == '0) begin
      return DH'(1);
    end
    return ve;
  endfunction

  // both unused mode codes behave as eighths
  function automatic logic [1:0] shift_of(input logic [MODE_W-1:0] mode);
    logic [1:0] sh;
    unique case (mode)
      MODE_HALF:    sh = SH_2;
      MODE_QUARTER: sh = SH_4;
      default:      sh = SH_8;
    endcase
    return sh;
  endfunction

  function automatic logic [LANE_BITS-1:0] mask_of(input logic [1:0] sh);
    logic [LANE_BITS-1:0] m;
    unique case (sh)
      SH_2:    m = 3'd1;
      SH_4:    m = 3'd3;
      default: m = 3'd7;
    endcase
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0] scale_mode, scale_mode_next;
  logic [DIM_W-1:0]  src_width, src_width_next;
  logic [DIM_W-1:0]  src_height, src_height_next;

  always_comb begin
    scale_mode_next = scale_mode;
    src_width_next  = src_width;
    src_height_next = src_height;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE_MODE: scale_mode_next = cfg_data[MODE_W-1:0];
        REG_SRC_WIDTH:  src_width_next  = cfg_data[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height_next = cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode <= SCALE_MODE_RST;
      src_width  <= SRC_WIDTH_RST;
      src_height <= SRC_HEIGHT_RST;
    end else begin
      scale_mode <= scale_mode_next;
      src_width  <= src_width_next;
      src_height <= src_height_next;
    end
  end

  // ---------------------------------------------------------------------------
  // position of the offered pixel
  // ---------------------------------------------------------------------------
  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  pix_t          held_left_pixel;

  logic [DW-1:0]        w_cur, tw;
  logic [DH-1:0]        h_cur, th;
  logic [1:0]           sh_cur;
  logic [LANE_BITS-1:0] mask_cur, xm, ym;
  logic [CW-1:0]        x_cur, bx, idx_cur;
  logic [RW-1:0]        y_cur, by;
  logic                 in_block, fold, le_cur, fe_cur, x_wrap;
  logic                 in_acc;
  logic [LANE_BITS-1:0] lane_cur, lane_base;
  logic [RA-1:0]        row_cur;

  assign w_cur    = eff_width(src_width);
  assign h_cur    = eff_height(src_height);
  assign sh_cur   = shift_of(scale_mode);
  assign mask_cur = mask_of(sh_cur);
  assign tw       = w_cur >> sh_cur;
  assign th       = h_cur >> sh_cur;

  // start of frame or a counter left beyond a shrunk dimension restarts it
  assign x_cur = (s_tuser || DW'(column_count) >= w_cur) ? '0 : column_count;
  assign y_cur = (s_tuser || DH'(row_count) >= h_cur) ? '0 : row_count;

  assign xm = LANE_BITS'(x_cur) & mask_cur;
  assign ym = LANE_BITS'(y_cur) & mask_cur;
  assign bx = x_cur >> sh_cur;
  assign by = y_cur >> sh_cur;

  // second column of a whole block: store the pair, fold on its last row
  assign in_block = (xm == LANE_BITS'(1)) && (DW'(bx) < tw) && (DH'(by) < th);
  assign fold     = in_block && (ym == mask_cur);
  assign le_cur   = (DW'(bx) == tw - DW'(1));
  assign fe_cur   = le_cur && (DH'(by) == th - DH'(1));

  // store entry: block column times block size plus row within block
  assign idx_cur   = (x_cur & ~CW'(mask_cur)) | CW'(ym);
  assign lane_cur  = LANE_BITS'(idx_cur);
  assign lane_base = lane_cur & ~mask_cur;
  assign row_cur   = RA'(idx_cur >> LANE_BITS);

  assign x_wrap = (DW'(x_cur) + DW'(1)) >= w_cur;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (in_acc) begin
      if (x_wrap) begin
        column_count_next = '0;
        row_count_next    = ((DH'(y_cur) + DH'(1)) >= h_cur) ? '0 : y_cur + RW'(1);
      end else begin
        column_count_next = x_cur + CW'(1);
        row_count_next    = y_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      held_left_pixel <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (in_acc && xm == '0) begin
        held_left_pixel <= s_tdata;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // line store read address: row that the next pixel would touch, taken from
  // the next counters and next registers so the row is ready in the next cycle, not later
  // ---------------------------------------------------------------------------
  logic [DW-1:0]        w_rd;
  logic [DH-1:0]        h_rd;
  logic [LANE_BITS-1:0] mask_rd;
  logic [CW-1:0]        x_rd, idx_rd;
  logic [RW-1:0]        y_rd;
  logic [RA-1:0]        row_rd;

  assign w_rd    = eff_width(src_width_next);
  assign h_rd    = eff_height(src_height_next);
  assign mask_rd = mask_of(shift_of(scale_mode_next));
  assign x_rd    = (DW'(column_count_next) >= w_rd) ? '0 : column_count_next;
  assign y_rd    = (DH'(row_count_next) >= h_rd) ? '0 : row_count_next;
  assign idx_rd  = (x_rd & ~CW'(mask_rd)) | CW'(LANE_BITS'(y_rd) & mask_rd);
  assign row_rd  = RA'(idx_rd >> LANE_BITS);

  // ---------------------------------------------------------------------------
  // line store: read row, replace this pixel's lane, write back
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] store_rdata, store_wdata;
  pix_t             pair_cur;
  pix_t             lane_val [LANES];
  pix_t             e_sel [LANES];

  assign pair_cur = pair_avg(held_left_pixel, s_tdata);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_val[l] = (LANE_BITS'(l) == lane_cur) ? pair_cur : store_rdata[l*PIX_W +: PIX_W];
      store_wdata[l*PIX_W +: PIX_W] = lane_val[l];
    end
    // block rows in order, lanes beyond the block size read as zero
    for (int i = 0; i < LANES; i++) begin
      e_sel[i] = (LANE_BITS'(i) <= mask_cur) ? lane_val[lane_base | LANE_BITS'(i)] : '0;
    end
  end

  rbd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (RAM_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (in_acc && in_block),
    .waddr (row_cur),
    .wdata (store_wdata),
    .raddr (row_rd),
    .rdata (store_rdata)
  );

  // ---------------------------------------------------------------------------
  // fold pipeline: gathered rows, first level, second level, output register
  // each stage moves on when the one after it is empty or moving
  // ---------------------------------------------------------------------------
  logic       v1, v2, v3;
  logic       load1, load2, load3, out_take;
  logic       adv1, adv2, adv3;
  pix_t       e1 [LANES];
  pix_t       a2 [4];
  pix_t       b3 [2];
  pix_t       a_c [4];
  pix_t       b_c [2];
  logic [1:0] sh1, sh2, sh3;
  logic       le1, le2, le3, fe1, fe2, fe3;

  assign out_take = v3 && (!m_tvalid || m_tready);
  assign adv3     = !v3 || out_take;
  assign load3    = v2 && adv3;
  assign adv2     = !v2 || load3;
  assign load2    = v1 && adv2;
  assign adv1     = !v1 || load2;
  assign s_tready = adv1;
  assign in_acc   = s_tvalid && s_tready;
  assign load1    = in_acc && fold;

  // first level: halves pair rows 0,1; otherwise rows two apart
  assign a_c[0] = (sh1 == SH_2) ? pair_avg(e1[0], e1[1]) : pair_avg(e1[0], e1[2]);
  assign a_c[1] = pair_avg(e1[4], e1[6]);
  assign a_c[2] = pair_avg(e1[1], e1[3]);
  assign a_c[3] = pair_avg(e1[5], e1[7]);

  // second level: halves pass through, quarters finish here; eighths form even and odd halves
  always_comb begin
    case (sh2)
      SH_2:    b_c[0] = a2[0];
      SH_4:    b_c[0] = pair_avg(a2[0], a2[2]);
      default: b_c[0] = pair_avg(a2[0], a2[1]);
    endcase
    b_c[1] = pair_avg(a2[2], a2[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      v1       <= load1 | (v1 & ~load2);
      v2       <= load2 | (v2 & ~load3);
      v3       <= load3 | (v3 & ~out_take);
      m_tvalid <= out_take | (m_tvalid & ~m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      e1  <= e_sel;
      sh1 <= sh_cur;
      le1 <= le_cur;
      fe1 <= fe_cur;
    end
    if (load2) begin
      a2  <= a_c;
      sh2 <= sh1;
      le2 <= le1;
      fe2 <= fe1;
    end
    if (load3) begin
      b3  <= b_c;
      sh3 <= sh2;
      le3 <= le2;
      fe3 <= fe2;
    end
    if (out_take) begin
      m_tdata <= (sh3 == SH_8) ? pair_avg(b3[0], b3[1]) : b3[0];
      m_tlast <= le3;
      m_tuser <= fe3;
    end
  end

endmodule

/* hdl/rbd_ram.sv */
// rbd_ram: generic simple dual-port ram, one write port, one read port
// with registered read data; no dependencies
module rbd_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/rbd_checker.sv */
// rbd_checker: port-level assertions for the rgb565 box downscaler core,
// attached by the bind at the end of this file; depends on rbd_pkg
module rbd_checker (
  input logic          clk,
  input logic          rst,
  input logic          s_tready,
  input logic          m_tvalid,
  input logic          m_tready,
  input rbd_pkg::pix_t m_tdata,
  input logic          m_tlast,
  input logic          m_tuser
);

  import rbd_pkg::*;

  // the last pixel of a frame also closes its row
  a_frame_end_is_line_end: assert property (
    @(posedge clk) disable iff (rst) (m_tvalid && m_tuser) |-> m_tlast
  ) else $error("frame end without line end");

  // the input side only stalls behind a full, blocked output
  a_stall_needs_full_output: assert property (
    @(posedge clk) disable iff (rst) !s_tready |-> (m_tvalid && !m_tready)
  ) else $error("input stalled while output could move");

  // nothing is offered straight after reset
  a_quiet_after_reset: assert property (
    @(posedge clk) disable iff (rst) $past(rst) |-> !m_tvalid
  ) else $error("output valid right after reset");

  // a blocked transaction keeps its payload
  a_out_hold: assert property (
    @(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=>
        (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
  ) else $error("output transaction changed while stalled");

endmodule

bind rgb565_box_downscale_core rbd_checker u_rbd_checker (.*);
